### src/mcst_pkg.sv
// ----------------------------------------------------------------------------
// mcst_pkg
// Types, constants and codes shared by the soft timer bank modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcst_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = 3;
  localparam int TIME_W     = 32;
  localparam int REM_W      = TIME_W + 1;
  localparam int MASK_W     = 8;
  localparam int CNT_W      = 4;
  localparam int SCAN_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_RESTART = 3'd4,
    OP_SETIVL  = 3'd5,
    OP_STOPALL = 3'd6,
    OP_QUERY   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_REJ = 1'b1
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic              latch;
    logic              scan;
    logic [SCAN_W-1:0] scan_idx;
    logic              exec;
    logic              calc;
    logic              load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/mcst_cmd_if.sv
// ----------------------------------------------------------------------------
// mcst_cmd_if
// Command channel: valid/ready handshake with the timer command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcst_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [2:0]  timer_index;
  logic [31:0] interval;
  logic        reload_en;

  modport source (output valid, op, timer_index, interval, reload_en, input ready);
  modport sink   (input valid, op, timer_index, interval, reload_en, output ready);
endinterface

`default_nettype wire

### src/mcst_res_if.sv
// ----------------------------------------------------------------------------
// mcst_res_if
// Result channel: valid/ready handshake with the timer result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcst_res_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [7:0]         fired_mask;
  logic               running;
  logic signed [32:0] remaining;
  logic [3:0]         num_active;

  modport source (output valid, status, fired_mask, running, remaining, num_active,
                  input ready);
  modport sink   (input valid, status, fired_mask, running, remaining, num_active,
                  output ready);
endinterface

`default_nettype wire

### src/multi_channel_soft_timer_bank.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank
// Bank of NUM_TIMERS one-shot / auto-reload timers driven by a command stream.
// ----------------------------------------------------------------------------
// Every command gives exactly one result. A tick passes through the expiry
// scan, in which the single table read port visits one timer per cycle, and
// then the execute, calc and done states; every other command goes straight
// to the execute, calc and done states. One command is in flight at a time, and a new one is
// accepted once the previous result sits in the output register. Timer state
// is valid straight out of reset; no initialization pass is needed.
`default_nettype none

module multi_channel_soft_timer_bank (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcst_cmd_if.sink    cmd_i,
  mcst_res_if.source  res_o
);
  import mcst_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mcst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  mcst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .op_i           (cmd_i.op),
    .timer_index_i  (cmd_i.timer_index),
    .interval_i     (cmd_i.interval),
    .reload_en_i    (cmd_i.reload_en),
    .status_o       (res_o.status),
    .fired_mask_o   (res_o.fired_mask),
    .running_o      (res_o.running),
    .remaining_o    (res_o.remaining),
    .num_active_o   (res_o.num_active)
  );

  // a transaction keeps the bank busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while previous one still in progress");

  // an idle timer reports -1, a running one never does
  a_running_vs_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.running == (res_o.remaining != '1)))
    else $error("running flag and remaining time disagree");

  a_count_covers_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.running) |-> (res_o.num_active != '0))
    else $error("running timer not counted as active");

endmodule

`default_nettype wire

### src/mcst_ctrl.sv
// ----------------------------------------------------------------------------
// mcst_ctrl
// Sequencer: accept, timer scan on tick, execute, remaining-time calc, report.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire mcst_pkg::dp_stat_t stat_i,
  output mcst_pkg::dp_cmd_t       cmd_o
);
  import mcst_pkg::*;

  state_e            state_q, state_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              slot_free;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_d  = '0;
          state_d = stat_i.is_tick ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (scan_q == SCAN_W'(NUM_TIMERS - 1)) begin
          state_d = ST_EXEC;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_EXEC: state_d = ST_CALC;
      ST_CALC: state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.scan_idx = scan_q;
    cmd_o.latch    = accept;
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.calc     = (state_q == ST_CALC);
    cmd_o.load     = (state_q == ST_DONE) && slot_free;
    in_ready_o     = (state_q == ST_IDLE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### src/mcst_dp.sv
// ----------------------------------------------------------------------------
// mcst_dp
// Timer tables, time count, per-command update and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_dp (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mcst_pkg::dp_cmd_t       cmd_i,
  output mcst_pkg::dp_stat_t           stat_o,
  input  wire logic [2:0]              op_i,
  input  wire logic [mcst_pkg::IDX_W-1:0] timer_index_i,
  input  wire logic [31:0]             interval_i,
  input  wire logic                    reload_en_i,
  output logic                         status_o,
  output logic [mcst_pkg::MASK_W-1:0]  fired_mask_o,
  output logic                         running_o,
  output logic signed [mcst_pkg::REM_W-1:0] remaining_o,
  output logic [mcst_pkg::CNT_W-1:0]   num_active_o
);
  import mcst_pkg::*;

  // latched command
  op_e               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TIME_W-1:0] ivl_q;
  logic              rl_q;

  logic [TIME_W-1:0] time_q;
  logic [TIME_W-1:0] ivl_tab_q   [NUM_TIMERS];
  logic [TIME_W-1:0] start_tab_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] en_q, en_d;
  logic [NUM_TIMERS-1:0] rl_tab_q, rl_tab_d;
  logic [NUM_TIMERS-1:0] cr_q, cr_d;

  logic              rej_q;
  logic [MASK_W-1:0] fired_q;
  logic [TIME_W-1:0] gone_q;

  logic              idx_ok;
  logic [SCAN_W-1:0] addr;
  logic [TIME_W-1:0] rd_ivl, rd_start, diff;
  logic              rd_en, rd_cr, rd_rl, due, hit;
  logic              ivl_we, st_we, rej_now;
  logic [TIME_W-1:0] st_wd;
  logic              run;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;

  assign stat_o.is_tick = (op_e'(op_i) == OP_TICK);

  assign idx_ok = int'(idx_q) < NUM_TIMERS;
  // one read port: scan walks the entries, otherwise the addressed timer
  assign addr   = cmd_i.scan ? cmd_i.scan_idx : SCAN_W'(idx_q);

  assign rd_ivl   = ivl_tab_q[addr];
  assign rd_start = start_tab_q[addr];
  assign rd_en    = en_q[addr];
  assign rd_cr    = cr_q[addr];
  assign rd_rl    = rl_tab_q[addr];
  assign diff     = time_q - rd_start;
  assign due      = diff >= rd_ivl;
  assign hit      = cmd_i.scan && rd_en && rd_cr && due;

  always_comb begin
    en_d     = en_q;
    cr_d     = cr_q;
    rl_tab_d = rl_tab_q;
    ivl_we   = 1'b0;
    st_we    = 1'b0;
    st_wd    = time_q;
    rej_now  = 1'b0;
    if (hit) begin
      if (rd_rl) begin
        st_we = 1'b1;
      end else begin
        en_d[addr] = 1'b0;
      end
    end else if (cmd_i.exec) begin
      unique case (op_q)
        OP_TICK: ;
        OP_CREATE: begin
          if (!idx_ok || ivl_q == '0) begin
            rej_now = 1'b1;
          end else begin
            ivl_we         = 1'b1;
            rl_tab_d[addr] = rl_q;
            cr_d[addr]     = 1'b1;
            en_d[addr]     = 1'b0;
            st_we          = 1'b1;
            st_wd          = '0;
          end
        end
        OP_START: begin
          if (!idx_ok || !rd_cr) begin
            rej_now = 1'b1;
          end else begin
            en_d[addr] = 1'b1;
            st_we      = 1'b1;
          end
        end
        OP_STOP: begin
          if (!idx_ok) begin
            rej_now = 1'b1;
          end else begin
            en_d[addr] = 1'b0;
          end
        end
        OP_RESTART: begin
          if (!idx_ok || !rd_en) begin
            rej_now = 1'b1;
          end else begin
            st_we = 1'b1;
          end
        end
        OP_SETIVL: begin
          if (!idx_ok || ivl_q == '0) begin
            rej_now = 1'b1;
          end else begin
            ivl_we = 1'b1;
            st_we  = rd_en;
          end
        end
        OP_STOPALL: en_d = '0;
        OP_QUERY:   rej_now = !idx_ok;
        default: ;
      endcase
    end
  end

  // result fields for the addressed timer, after the command, and the count of running timers
  always_comb begin
    run = idx_ok && en_q[addr];
    if (!run) begin
      rem = '1;
    end else if (gone_q >= rd_ivl) begin
      rem = '0;
    end else begin
      rem = {1'b0, rd_ivl - gone_q};
    end
    cnt = '0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      cnt = cnt + CNT_W'(en_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      en_q     <= '0;
      cr_q     <= '0;
      rl_tab_q <= '0;
    end else begin
      en_q     <= en_d;
      cr_q     <= cr_d;
      rl_tab_q <= rl_tab_d;
      if (cmd_i.latch && stat_o.is_tick) begin
        time_q <= time_q + 1'b1;
      end
    end
  end

  // table entries are used only once a create has written them
  always_ff @(posedge clk_i) begin
    if (ivl_we) begin
      ivl_tab_q[addr] <= ivl_q;
    end
    if (st_we) begin
      start_tab_q[addr] <= st_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_e'(op_i);
      idx_q   <= timer_index_i;
      ivl_q   <= interval_i;
      rl_q    <= reload_en_i;
      rej_q   <= 1'b0;
      fired_q <= '0;
    end
    if (hit) begin
      fired_q <= fired_q | (MASK_W'(1) << addr);
    end
    if (cmd_i.exec) begin
      rej_q <= rej_now;
    end
    if (cmd_i.calc) begin
      gone_q <= diff;
    end
    if (cmd_i.load) begin
      status_o       <= rej_q ? STATUS_REJ : STATUS_OK;
      fired_mask_o   <= fired_q;
      running_o      <= run;
      remaining_o    <= rem;
      num_active_o   <= cnt;
    end
  end

endmodule

`default_nettype wire
